// File: hw/rtl/tfu_pkg.sv
// ----------------------------------------------------------------------------
// tfu_pkg
// Source format codes, the result type and the channel widening helpers
// shared by the texel format unpacker.
// ----------------------------------------------------------------------------
package tfu_pkg;

	typedef enum logic [3:0] {
		FMT_A8       = 4'd0,
		FMT_I8       = 4'd1,
		FMT_A4I4     = 4'd2,
		FMT_P8       = 4'd3,
		FMT_RGB565   = 4'd4,
		FMT_ARGB1555 = 4'd5,
		FMT_ARGB4444 = 4'd6,
		FMT_AI88     = 4'd7,
		FMT_ARGB8888 = 4'd8,
		FMT_CMP      = 4'd9
	} fmt_t;

	typedef struct packed {
		logic [31:0] argb_word;
		logic        format_error;
	} tfu_result_t;

	function automatic logic [7:0] widen4(input logic [3:0] n);
		return {n, n};
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] n);
		return {n, n[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] n);
		return {n, n[5:4]};
	endfunction

endpackage

// File: hw/rtl/tfu_if.sv
// ----------------------------------------------------------------------------
// tfu_if
// Valid/ready channels of the texel format unpacker: raw texels in,
// expanded ARGB8888 words out.
// ----------------------------------------------------------------------------
interface tfu_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] raw_texel;

	modport source (output valid, output raw_texel, input ready);
	modport sink (input valid, input raw_texel, output ready);
endinterface

interface tfu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] argb_word;
	logic        format_error;

	modport source (output valid, output argb_word, output format_error, input ready);
	modport sink (input valid, input argb_word, input format_error, output ready);
endinterface

// File: hw/rtl/tfu_expand.sv
// ----------------------------------------------------------------------------
// tfu_expand
// Combinational expansion of one texel in the selected source format into
// an ARGB8888 word, with an error flag for palette, compressed and undefined formats.
// ----------------------------------------------------------------------------
module tfu_expand (
	input  tfu_pkg::fmt_t        fmt,
	input  logic [31:0]          raw,
	output tfu_pkg::tfu_result_t res
);
	import tfu_pkg::*;

	logic [7:0]  b8;
	logic [15:0] h16;

	assign b8  = raw[7:0];
	assign h16 = raw[15:0];

	always_comb begin
		res.argb_word    = '0;
		res.format_error = 1'b0;
		unique case (fmt)
			FMT_A8, FMT_I8: begin
				res.argb_word = {b8, b8, b8, b8};
			end
			FMT_A4I4: begin
				res.argb_word = {widen4(b8[7:4]), widen4(b8[3:0]),
					widen4(b8[3:0]), widen4(b8[3:0])};
			end
			FMT_RGB565: begin
				res.argb_word = {8'hff, widen5(h16[15:11]), widen6(h16[10:5]),
					widen5(h16[4:0])};
			end
			FMT_ARGB1555: begin
				res.argb_word = {{8{h16[15]}}, widen5(h16[14:10]), widen5(h16[9:5]),
					widen5(h16[4:0])};
			end
			FMT_ARGB4444: begin
				res.argb_word = {widen4(h16[15:12]), widen4(h16[11:8]),
					widen4(h16[7:4]), widen4(h16[3:0])};
			end
			FMT_AI88: begin
				res.argb_word = {h16[15:8], h16[7:0], h16[7:0], h16[7:0]};
			end
			FMT_ARGB8888: begin
				res.argb_word = raw;
			end
			default: begin
				res.argb_word    = '0;
				res.format_error = 1'b1;
			end
		endcase
	end

endmodule

// File: hw/rtl/texel_format_unpack_argb8888.sv
// ----------------------------------------------------------------------------
// texel_format_unpack_argb8888
// An accepted texel is captured in the input register, then expanded into the
// result register. Throughput is one item per cycle; the two registers form a
// two-stage pipeline that stalls only on output back-pressure.
// Reset clears both stage valids and sets the source format to ARGB8888.
// ----------------------------------------------------------------------------
module texel_format_unpack_argb8888 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	tfu_in_if.sink      texel_in,
	tfu_out_if.source   argb_out
);
	import tfu_pkg::*;

	fmt_t        fmt_q;
	logic        valid_s1;
	logic [31:0] raw_s1;
	logic        valid_s2;
	tfu_result_t res_s2;
	tfu_result_t res_c;
	logic        adv_s1;

	assign adv_s1         = !valid_s2 || argb_out.ready;
	assign texel_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_ARGB8888;
		end else if (cfg_we) begin
			fmt_q <= fmt_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (texel_in.ready) begin
				valid_s1 <= texel_in.valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (texel_in.valid && texel_in.ready) begin
			raw_s1 <= texel_in.raw_texel;
		end
		if (valid_s1 && adv_s1) begin
			res_s2 <= res_c;
		end
	end

	tfu_expand u_expand (
		.fmt (fmt_q),
		.raw (raw_s1),
		.res (res_c)
	);

	assign argb_out.valid        = valid_s2;
	assign argb_out.argb_word    = res_s2.argb_word;
	assign argb_out.format_error = res_s2.format_error;

endmodule

// File: hw/rtl/tfu_checker.sv
// ----------------------------------------------------------------------------
// tfu_checker
// Port-level checks of the texel format unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module tfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [3:0]  cfg_wdata,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_argb_word,
	input logic        out_format_error
);
	import tfu_pkg::*;

	logic [3:0] fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_ARGB8888;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_argb_word)
			&& $stable(out_format_error))
		else $error("Stalled result item changed or vanished.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_format_error |-> out_argb_word == 32'd0)
		else $error("Format error item carries nonzero data.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("Accepted item did not reach the output in two cycles.");

	a_err_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_format_error == (fmt_q == FMT_P8 || fmt_q > FMT_ARGB8888))
		else $error("Format error flag disagrees with the source format.");

	a_rgb565_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fmt_q == FMT_RGB565 |-> out_argb_word[31:24] == 8'hff)
		else $error("RGB565 item is not opaque.");

endmodule

bind texel_format_unpack_argb8888 tfu_checker u_tfu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_we           (cfg_we),
	.cfg_wdata        (cfg_wdata),
	.in_valid         (texel_in.valid),
	.in_ready         (texel_in.ready),
	.out_valid        (argb_out.valid),
	.out_ready        (argb_out.ready),
	.out_argb_word    (argb_out.argb_word),
	.out_format_error (argb_out.format_error)
);

// File: test/texel_format_unpack_argb8888_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_unpack_argb8888_tb
// Streams texels through the unpacker under every source format code, the
// undefined ones included, and compares each expanded ARGB8888 word and error
// flag against an in-order prediction, with random bursts and stalls.
// ----------------------------------------------------------------------------
import tfu_pkg::*;

class texel_scoreboard;
	logic [3:0]  src_format;
	tfu_result_t expected_q[$];
	int          checked_count;
	int          mismatch_count;
	bit [15:0]   formats_seen;

	function new();
		src_format = FMT_ARGB8888;
	endfunction

	function void set_format(input logic [3:0] code);
		src_format = code;
	endfunction

	function tfu_result_t expand_texel(input logic [31:0] raw);
		tfu_result_t res;
		logic [15:0] h16;
		logic [7:0]  lo8;
		h16 = raw[15:0];
		lo8 = raw[7:0];
		res.argb_word = '0;
		res.format_error = 1'b0;
		case (src_format)
			FMT_A8, FMT_I8: begin
				res.argb_word = {4{lo8}};
			end
			FMT_A4I4: begin
				res.argb_word = {lo8[7:4], lo8[7:4], {3{lo8[3:0], lo8[3:0]}}};
			end
			FMT_RGB565: begin
				res.argb_word = {8'hff, h16[15:11], h16[15:13], h16[10:5], h16[10:9],
					h16[4:0], h16[4:2]};
			end
			FMT_ARGB1555: begin
				res.argb_word = {{8{h16[15]}}, h16[14:10], h16[14:12], h16[9:5], h16[9:7],
					h16[4:0], h16[4:2]};
			end
			FMT_ARGB4444: begin
				res.argb_word = {h16[15:12], h16[15:12], h16[11:8], h16[11:8],
					h16[7:4], h16[7:4], h16[3:0], h16[3:0]};
			end
			FMT_AI88: begin
				res.argb_word = {h16[15:8], lo8, lo8, lo8};
			end
			FMT_ARGB8888: begin
				res.argb_word = raw;
			end
			default: begin
				res.format_error = 1'b1;
			end
		endcase
		return res;
	endfunction

	function void note_texel(input logic [31:0] raw);
		expected_q.push_back(expand_texel(raw));
		formats_seen[src_format] = 1'b1;
	endfunction

	function void check_word(input logic [31:0] argb, input logic err);
		tfu_result_t want;
		if (expected_q.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected item argb_word=%h format_error=%b", $time, argb, err);
			return;
		end
		want = expected_q.pop_front();
		checked_count++;
		if (argb !== want.argb_word) begin
			mismatch_count++;
			$display("%0t: argb_word expected %h actual %h", $time, want.argb_word, argb);
		end
		if (err !== want.format_error) begin
			mismatch_count++;
			$display("%0t: format_error expected %b actual %b", $time, want.format_error, err);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module texel_format_unpack_argb8888_tb;

	localparam logic [3:0] FMT_UNDEF_LO = 4'd10;
	localparam logic [3:0] FMT_UNDEF_HI = 4'd15;
	localparam int DIR_COUNT = 19;
	localparam int RANDOM_ITEMS = 1130;
	localparam int LONG_HOLD_CYCLES = 90;

	localparam logic [3:0] DIR_FMT [DIR_COUNT] = '{
		FMT_ARGB8888, FMT_ARGB8888, FMT_ARGB8888, FMT_A8, FMT_I8, FMT_A4I4, FMT_A4I4,
		FMT_P8, FMT_RGB565, FMT_RGB565, FMT_ARGB1555, FMT_ARGB1555, FMT_ARGB4444,
		FMT_ARGB4444, FMT_AI88, FMT_AI88, FMT_CMP, FMT_UNDEF_HI, FMT_UNDEF_LO};
	localparam logic [31:0] DIR_RAW [DIR_COUNT] = '{
		32'h0000_0000, 32'hffff_ffff, 32'ha5c3_0f81, 32'hdead_be7f, 32'hffff_ff80,
		32'h0000_00f0, 32'hffff_ff0f, 32'h0000_0012, 32'h0000_ffff, 32'habcd_07e0,
		32'h0000_8000, 32'hffff_7fff, 32'h0000_f000, 32'h1234_0fa5, 32'hffff_ff00,
		32'h0000_00ff, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001};

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	int          burst_left = 0;
	int          gap_len = 0;
	int          format_writes = 0;

	texel_scoreboard sb = new();

	tfu_in_if  texel_in();
	tfu_out_if argb_out();

	texel_format_unpack_argb8888 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.texel_in  (texel_in),
		.argb_out  (argb_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && texel_in.valid && texel_in.ready) begin
			sb.note_texel(texel_in.raw_texel);
		end
		if (arst_n && argb_out.valid && argb_out.ready) begin
			sb.check_word(argb_out.argb_word, argb_out.format_error);
		end
	end

	initial begin
		rx_mode_e rx_mode;
		int       rx_left;
		int       hold_left;
		bit       hold_done;
		rx_mode = RX_OPEN;
		rx_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		argb_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && hold_left == 0 && texel_in.valid && sb.checked_count >= 300) begin
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0) begin
					hold_done = 1'b1;
				end
				argb_out.ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_e'($urandom_range(0, 3));
					rx_left = $urandom_range(10, 60);
				end
				rx_left--;
				case (rx_mode)
					RX_OPEN:   argb_out.ready <= 1'b1;
					RX_COIN:   argb_out.ready <= $urandom_range(0, 1);
					RX_SPARSE: argb_out.ready <= ($urandom_range(0, 3) == 0);
					default:   argb_out.ready <= (rx_left % 3) != 0;
				endcase
			end
		end
	end

	function automatic logic [31:0] random_texel();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hffff_ffff;
			2:       return 32'h1 << $urandom_range(0, 31);
			3:       return ~(32'h1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	task automatic set_format(input logic [3:0] code);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_format(code);
		format_writes++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic feed_texel(input logic [31:0] raw, input bit phase_end);
		bit drop;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		drop = phase_end || (burst_left == 1 && gap_len != 0);
		texel_in.valid <= 1'b1;
		texel_in.raw_texel <= raw;
		do @(posedge clk); while (!texel_in.ready);
		burst_left--;
		if (drop) begin
			texel_in.valid <= 1'b0;
		end
		if (burst_left == 0 && gap_len != 0) begin
			repeat (gap_len) @(posedge clk);
		end
	endtask

	initial begin
		int         phase;
		int         phase_len;
		int         sent;
		logic [3:0] code;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		texel_in.valid <= 1'b0;
		texel_in.raw_texel <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_COUNT; i++) begin
			if (DIR_FMT[i] != sb.src_format) begin
				wait_drained();
				set_format(DIR_FMT[i]);
			end
			feed_texel(DIR_RAW[i], 1'b1);
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			code = (phase < 16) ? phase[3:0] : 4'($urandom_range(0, 15));
			phase_len = (phase % 5 == 4) ? $urandom_range(80, 160) : $urandom_range(30, 70);
			if (phase_len > RANDOM_ITEMS - sent) begin
				phase_len = RANDOM_ITEMS - sent;
			end
			wait_drained();
			set_format(code);
			for (int i = 0; i < phase_len; i++) begin
				feed_texel(random_texel(), i == phase_len - 1);
			end
			sent += phase_len;
			phase++;
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Checked %0d texels over %0d format writes; format codes seen: %b.",
			sb.checked_count, format_writes, sb.formats_seen);
		if (sb.mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule
